@@ src/escape_sequence_decoder_macros.svh @@
// Assertion macros for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every edge outside reset.
`define ESD_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("escape_sequence_decoder: invariant violated");
// Check that a condition implies a consequence at the next edge.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape_sequence_decoder: sequence check failed");
`else
`define ESD_ASSERT_ALWAYS(label, clk, rst, prop)
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/esd_pkg.sv @@
// Shared types, constants and the escape letter map for the escape sequence decoder.
package esd_pkg;

  // Decoder mode; the unused code is treated as normal text
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  localparam logic [7:0] BACKSLASH  = 8'h5C;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [1:0] MAX_DIGITS = 2'd3;
  localparam int         MAX_RESULTS = 3;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // One decoded output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // Results produced by one input transaction
  typedef struct packed {
    logic [1:0]  cnt;
    item_t [2:0] item;
  } res_t;

  // Map the letter after a backslash to its control code
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'h07; // a
      8'h62:   r = 8'h08; // b
      8'h66:   r = 8'h0C; // f
      8'h6E:   r = 8'h0A; // n
      8'h74:   r = 8'h09; // t
      8'h72:   r = 8'h0D; // r
      8'h76:   r = 8'h0B; // v
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
  endfunction

endpackage

@@ src/escape_sequence_decoder.sv @@
// A decoded byte is registered into the result queue and offered on the output from there.
// Throughput: one input byte per cycle while each byte yields at most one result and the
// output is not stalled; a byte that yields two or three results stalls the input until
// the single output port has drained the four-entry result queue down to one entry.
// Reset: synchronous; clears the decode state and empties the result queue.
// Top level of the escape sequence decoder.
`include "escape_sequence_decoder_macros.svh"

module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  esd_pkg::res_t res;
  esd_pkg::item_t mem [esd_pkg::FIFO_DEPTH];
  logic [esd_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [esd_pkg::CNT_W-1:0] cnt, cnt_next;
  logic push, pop;

  // Take a transaction only when the queue has room for the largest burst
  assign in_stall  = (cnt > esd_pkg::CNT_W'(esd_pkg::FIFO_DEPTH - esd_pkg::MAX_RESULTS));
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt != '0);
  assign pop       = out_valid && !out_stall;

  esd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (push),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Write the results of an accepted transaction into consecutive entries
  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < esd_pkg::MAX_RESULTS; k++) begin
        if (2'(k) < res.cnt) begin
          mem[wr_ptr + esd_pkg::PTR_W'(k)] <= res.item[k];
        end
      end
    end
  end

  // Track fill level
  always_comb begin
    cnt_next = cnt + (push ? {1'b0, res.cnt} : '0) - (pop ? esd_pkg::CNT_W'(1) : '0);
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + res.cnt;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + esd_pkg::PTR_W'(1);
      end
      cnt <= cnt_next;
    end
  end

  assign out_byte = mem[rd_ptr].data;
  assign out_last = mem[rd_ptr].last;

  // Queue never overfills
  `ESD_ASSERT_ALWAYS(a_no_overflow, clk, rst, cnt <= esd_pkg::CNT_W'(esd_pkg::FIFO_DEPTH))
  // A stalled result stays offered
  `ESD_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid)
  // The last byte of a string always leaves at least the terminator queued
  `ESD_ASSERT_NEXT(a_term_queued, clk, rst, push && in_last, out_valid)

endmodule

@@ src/esd_decode.sv @@
// Escape decoding state and the per-byte result logic.
module esd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output esd_pkg::res_t res
);

  esd_pkg::mode_t mode, mode_next;
  logic [1:0]     digit_count, digit_count_next;
  logic [7:0]     numeric_value, numeric_value_next;

  // Build the results and the next state for the byte on the input
  always_comb begin
    logic [1:0] n;
    logic [1:0] cnt_inc;
    logic [7:0] acc;
    n                  = 2'd0;
    cnt_inc            = digit_count + 2'd1;
    acc                = {numeric_value[4:0], 3'b000} + {4'b0000, in_byte[3:0]};
    res                = '0;
    mode_next          = mode;
    digit_count_next   = digit_count;
    numeric_value_next = numeric_value;

    case (mode)
      esd_pkg::MODE_NUMBER: begin
        if (esd_pkg::is_digit(in_byte) && (digit_count < esd_pkg::MAX_DIGITS)) begin
          numeric_value_next = acc;
          digit_count_next   = cnt_inc;
          if (cnt_inc >= esd_pkg::MAX_DIGITS) begin
            res.item[n]        = '{data: acc, last: 1'b0};
            n                  = n + 2'd1;
            mode_next          = esd_pkg::MODE_NORMAL;
            digit_count_next   = 2'd0;
            numeric_value_next = 8'd0;
          end
        end else begin
          // Flush the number, then treat the byte as normal text
          res.item[n]        = '{data: numeric_value, last: 1'b0};
          n                  = n + 2'd1;
          mode_next          = esd_pkg::MODE_NORMAL;
          digit_count_next   = 2'd0;
          numeric_value_next = 8'd0;
          if (in_byte == esd_pkg::BACKSLASH) begin
            mode_next = esd_pkg::MODE_ESCAPE;
          end else begin
            res.item[n] = '{data: in_byte, last: 1'b0};
            n           = n + 2'd1;
          end
        end
      end
      esd_pkg::MODE_ESCAPE: begin
        if (esd_pkg::is_digit(in_byte)) begin
          mode_next          = esd_pkg::MODE_NUMBER;
          digit_count_next   = 2'd1;
          numeric_value_next = {4'b0000, in_byte[3:0]};
        end else begin
          res.item[n] = '{data: esd_pkg::escape_map(in_byte), last: 1'b0};
          n           = n + 2'd1;
          mode_next   = esd_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_next = esd_pkg::MODE_NORMAL;
        if (in_byte == esd_pkg::BACKSLASH) begin
          mode_next = esd_pkg::MODE_ESCAPE;
        end else begin
          res.item[n] = '{data: in_byte, last: 1'b0};
          n           = n + 2'd1;
        end
      end
    endcase

    // End of string: flush a pending number, add the terminator, clear state
    if (in_last) begin
      if (mode_next == esd_pkg::MODE_NUMBER) begin
        res.item[n] = '{data: numeric_value_next, last: 1'b0};
        n           = n + 2'd1;
      end
      res.item[n]        = '{data: 8'd0, last: 1'b1};
      n                  = n + 2'd1;
      mode_next          = esd_pkg::MODE_NORMAL;
      digit_count_next   = 2'd0;
      numeric_value_next = 8'd0;
    end

    res.cnt = n;
  end

  // Advance the state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= esd_pkg::MODE_NORMAL;
      digit_count   <= 2'd0;
      numeric_value <= 8'd0;
    end else if (accept) begin
      mode          <= mode_next;
      digit_count   <= digit_count_next;
      numeric_value <= numeric_value_next;
    end
  end

endmodule
